/* src/fods_pkg.sv */
// Shared types and constants of the fourth-order diffusion stencil.
`default_nettype none

package fods_pkg;

  // Field and register widths
  localparam int SAMPLE_W  = 24;
  localparam int GAIN_W    = 16;
  localparam int WIDTH_W   = 10;
  localparam int HEIGHT_W  = 13;
  localparam int PCNT_W    = 13;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Neighborhood geometry
  localparam int LINES  = 4;
  localparam int WIN    = 5;
  localparam int LINE_W = LINES * SAMPLE_W;

  // Arithmetic widths
  localparam int PART_W = SAMPLE_W + 2;      // sum of four samples
  localparam int SUM_W  = SAMPLE_W + 7;      // full stencil sum
  localparam int PROD_W = SUM_W + GAIN_W + 1;
  localparam int Q_W    = PROD_W - 16;
  localparam int VAL_W  = Q_W + 2;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_PLANES = 2'd3
  } fods_reg_t;

  typedef logic signed [SAMPLE_W-1:0] fods_sample_t;

  // Position flags that travel with a word
  typedef struct packed {
    logic interior;
    logic last;
  } fods_side_t;

  // One result word
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       volume_end;
  } fods_result_t;

endpackage

`default_nettype wire

/* src/fourth_order_diffusion_stencil.sv */
// Top level of the 13-point fourth-order diffusion stencil.
//
//   channel | ports                                   | word
//   --------+-----------------------------------------+-----------------------------
//   in      | in_valid, in_ready, in_sample           | one padded sample, raster
//   out     | out_valid, out_ready, out_value/_end    | one diffused interior point
//   cfg     | cfg_we, cfg_index, cfg_data             | register write, no wait
//
// One sample is taken per clock while in_ready is high. A result enters the
// output queue once the sample that completes its window has passed the line
// store read, the window shift, two summing stages and the multiply, with rounding
// and saturation on the queue input. Reset clears counters and pipeline valids at
// once; the line store needs no clearing pass, a fill count makes unwritten
// columns read as zero. in_ready drops only when the eight-word queue plus words
// still in the pipeline would fill it, so input flows on while a result waits.
`default_nettype none

module fourth_order_diffusion_stencil #(
  parameter int HALO    = 2,
  parameter int MAX_ROW = 1024
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [fods_pkg::SAMPLE_W-1:0]      in_sample,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [fods_pkg::SAMPLE_W-1:0]      out_value,
  output logic                                      out_volume_end,
  input  logic                                      cfg_we,
  input  logic [fods_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [fods_pkg::CFG_W-1:0]                cfg_data
);
  import fods_pkg::*;

  localparam int AW  = $clog2(MAX_ROW);
  localparam int CW  = ((AW > WIDTH_W) ? AW : WIDTH_W) + 2;
  localparam int RW  = HEIGHT_W + 1;
  localparam int PW1 = PCNT_W + 1;
  localparam int LIM = MAX_ROW - 2 * HALO;

  // Configuration registers
  logic [GAIN_W-1:0]   gain_r;
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [PCNT_W-1:0]   planes_r;

  // Position counters
  logic [AW-1:0]       col_r, col_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  logic [PCNT_W-1:0]   plane_r, plane_nxt;

  // Position decode of the current word
  logic [CW-1:0]       nx, w, c, c_inc;
  logic [RW-1:0]       h, r1, r, r_inc;
  logic [PCNT_W-1:0]   pc, p;
  logic [PW1-1:0]      p1, p_inc;
  logic                col_wrap, row_wrap;
  fods_side_t          side;

  // Stage one
  logic                run_r;
  logic                accept;
  logic                s1_vld_r;
  logic [AW-1:0]       s1_addr_r;
  fods_sample_t        s1_sample_r;
  fods_side_t          s1_side_r;
  logic [LINE_W-1:0]   lines_rd, lines_wr;
  logic signed [SAMPLE_W-1:0] column [WIN];

  // Downstream
  logic                      sum_vld;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SAMPLE_W-1:0] ctr;
  logic                      sum_last;
  logic [1:0]                win_busy;
  logic                      push;
  fods_result_t              push_data;
  fods_result_t              head;
  logic                      pop;
  logic [FIFO_CW-1:0]        fifo_cnt;
  logic [FIFO_CW-1:0]        occupancy;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= '0;
      width_r  <= WIDTH_W'(1);
      height_r <= HEIGHT_W'(1);
      planes_r <= PCNT_W'(1);
    end else if (cfg_we) begin
      unique case (fods_reg_t'(cfg_index))
        REG_GAIN:   gain_r   <= cfg_data[GAIN_W-1:0];
        REG_WIDTH:  width_r  <= cfg_data[WIDTH_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[HEIGHT_W-1:0];
        REG_PLANES: planes_r <= cfg_data[PCNT_W-1:0];
      endcase
    end
  end

  // Plane geometry from the current registers
  always_comb begin
    nx = (CW'(width_r) > CW'(LIM)) ? CW'(LIM) : CW'(width_r);
    w  = nx + CW'(2 * HALO);
    h  = RW'(height_r) + RW'(2 * HALO);
    pc = (planes_r == '0) ? PCNT_W'(1) : planes_r;
  end

  // Wrap counters left beyond a limit, then locate the word and advance
  always_comb begin
    col_wrap = (CW'(col_r) >= w);
    c        = col_wrap ? '0 : CW'(col_r);
    r1       = col_wrap ? row_r + RW'(1) : row_r;
    row_wrap = (r1 >= h);
    r        = row_wrap ? '0 : r1;
    p1       = PW1'(plane_r) + (row_wrap ? PW1'(1) : PW1'(0));
    p        = (p1 >= PW1'(pc)) ? '0 : p1[PCNT_W-1:0];

    side.interior = (c >= CW'(HALO + 2)) && (c < nx + CW'(HALO + 2)) &&
                    (r >= RW'(HALO + 2)) && (r < RW'(height_r) + RW'(HALO + 2));
    side.last     = (c == nx + CW'(HALO + 1)) &&
                    (r == RW'(height_r) + RW'(HALO + 1)) &&
                    (PW1'(p) + PW1'(1) >= PW1'(pc));

    c_inc     = c + CW'(1);
    r_inc     = r + RW'(1);
    p_inc     = PW1'(p) + PW1'(1);
    col_nxt   = c_inc[AW-1:0];
    row_nxt   = r;
    plane_nxt = p;
    if (c_inc >= w) begin
      col_nxt = '0;
      if (r_inc >= h) begin
        row_nxt   = '0;
        plane_nxt = (p_inc >= PW1'(pc)) ? '0 : p_inc[PCNT_W-1:0];
      end else begin
        row_nxt = r_inc;
      end
    end
  end

  // Hold ready low until run_r is set after reset, and while queue plus pipeline words would fill the queue
  assign occupancy = fifo_cnt + FIFO_CW'(s1_vld_r) + FIFO_CW'(win_busy[1])
                   + FIFO_CW'(win_busy[0]) + FIFO_CW'(sum_vld) + FIFO_CW'(push);
  assign in_ready  = run_r && (occupancy < FIFO_CW'(FIFO_DEPTH));
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= 1'b0;
      col_r    <= '0;
      row_r    <= '0;
      plane_r  <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      run_r    <= 1'b1;
      s1_vld_r <= accept;
      if (accept) begin
        col_r   <= col_nxt;
        row_r   <= row_nxt;
        plane_r <= plane_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r   <= c[AW-1:0];
      s1_sample_r <= in_sample;
      s1_side_r   <= side;
    end
  end

  fods_line_store #(
    .MAX_ROW (MAX_ROW)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (c[AW-1:0]),
    .wr_en   (s1_vld_r),
    .wr_addr (s1_addr_r),
    .wr_data (lines_wr),
    .rd_data (lines_rd)
  );

  // Column of five: four stored lines plus the new sample; each line moves up one
  always_comb begin
    for (int k = 0; k < LINES; k++) begin
      column[k] = lines_rd[k*SAMPLE_W +: SAMPLE_W];
    end
    column[LINES] = s1_sample_r;
    for (int k = 0; k < LINES; k++) begin
      lines_wr[k*SAMPLE_W +: SAMPLE_W] = column[k+1];
    end
  end

  fods_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (s1_vld_r),
    .col_in    (column),
    .side_in   (s1_side_r),
    .sum_valid (sum_vld),
    .sum_out   (sum),
    .ctr_out   (ctr),
    .last_out  (sum_last),
    .busy      (win_busy)
  );

  fods_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (sum_vld),
    .sum_in  (sum),
    .ctr_in  (ctr),
    .last_in (sum_last),
    .gain    (gain_r),
    .res_vld (push),
    .res     (push_data)
  );

  assign pop = out_valid && out_ready;

  fods_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_vld  (out_valid),
    .head      (head),
    .count     (fifo_cnt)
  );

  assign out_value      = head.value;
  assign out_volume_end = head.volume_end;

  // Checks
  a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (fifo_cnt < FIFO_CW'(FIFO_DEPTH)) || pop)
    else $error("result queue overflow");

  a_push_latency: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> $past(accept && side.interior, 5))
    else $error("result without an interior word five cycles earlier");

  a_no_same_column: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && s1_vld_r) |-> (c[AW-1:0] != s1_addr_r))
    else $error("line store read and write hit one column in one cycle");

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && $stable(width_r)) |=> (CW'(col_r) < w))
    else $error("column counter beyond row width");

endmodule

`default_nettype wire

/* src/fods_line_store.sv */
// Four packed line stores in one synchronous memory, with fill count and bypass.
`default_nettype none

module fods_line_store #(
  parameter int MAX_ROW = 1024
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      rd_en,
  input  logic [$clog2(MAX_ROW)-1:0]                rd_addr,
  input  logic                                      wr_en,
  input  logic [$clog2(MAX_ROW)-1:0]                wr_addr,
  input  logic [fods_pkg::LINE_W-1:0]               wr_data,
  output logic [fods_pkg::LINE_W-1:0]               rd_data
);
  import fods_pkg::*;

  localparam int AW = $clog2(MAX_ROW);

  logic [LINE_W-1:0] mem [MAX_ROW];
  logic [LINE_W-1:0] q_r;
  logic [LINE_W-1:0] fwd_data_r;
  logic              fwd_r;
  logic              zero_r;
  logic [AW:0]       fill_r;
  logic [AW:0]       fill_nxt;
  logic              fresh;

  // Columns are visited upward from zero, so the written entries are a prefix
  assign fresh = ({1'b0, rd_addr} >= fill_r);

  always_comb begin
    fill_nxt = fill_r;
    if (rd_en && fresh) begin
      fill_nxt = {1'b0, rd_addr} + (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      zero_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (rd_en) begin
        zero_r <= fresh;
        fwd_r  <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  // Write back and read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // Never-written entries read as zero; same-edge write wins over stale data
  always_comb begin
    priority if (zero_r) begin
      rd_data = '0;
    end else if (fwd_r) begin
      rd_data = fwd_data_r;
    end else begin
      rd_data = q_r;
    end
  end

endmodule

`default_nettype wire

/* src/fods_window.sv */
// 5x5 window registers and the two-stage stencil sum.
`default_nettype none

module fods_window (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      shift_en,
  input  logic signed [fods_pkg::SAMPLE_W-1:0]      col_in [fods_pkg::WIN],
  input  fods_pkg::fods_side_t                      side_in,
  output logic                                      sum_valid,
  output logic signed [fods_pkg::SUM_W-1:0]         sum_out,
  output logic signed [fods_pkg::SAMPLE_W-1:0]      ctr_out,
  output logic                                      last_out,
  output logic [1:0]                                busy
);
  import fods_pkg::*;

  fods_sample_t win_r [WIN][WIN];
  logic         v2_r, l2_r;
  logic         v3_r, l3_r;
  logic         v4_r, l4_r;

  logic signed [PART_W-1:0]   nb_nxt, dg_nxt, far_nxt;
  logic signed [PART_W-1:0]   nb_r, dg_r, far_r;
  logic signed [SAMPLE_W-1:0] ctr3_r, ctr4_r;
  logic signed [SUM_W-1:0]    sum_nxt, sum_r;

  // Shift the window left and load the new column on the right
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int k = 0; k < WIN; k++) begin
        for (int j = 0; j < WIN-1; j++) begin
          win_r[k][j] <= win_r[k][j+1];
        end
        win_r[k][WIN-1] <= col_in[k];
      end
    end
  end

  // Group sums: edge neighbors, diagonals, distance-two points
  always_comb begin
    nb_nxt  = PART_W'(win_r[1][2]) + PART_W'(win_r[3][2])
            + PART_W'(win_r[2][1]) + PART_W'(win_r[2][3]);
    dg_nxt  = PART_W'(win_r[1][1]) + PART_W'(win_r[1][3])
            + PART_W'(win_r[3][1]) + PART_W'(win_r[3][3]);
    far_nxt = PART_W'(win_r[0][2]) + PART_W'(win_r[4][2])
            + PART_W'(win_r[2][0]) + PART_W'(win_r[2][4]);
  end

  // Weighted combination: 8*nb - 2*dg - far - 20*ctr
  always_comb begin
    sum_nxt = (SUM_W'(nb_r) <<< 3) - (SUM_W'(dg_r) <<< 1) - SUM_W'(far_r)
            - (SUM_W'(ctr3_r) <<< 4) - (SUM_W'(ctr3_r) <<< 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v2_r <= shift_en && side_in.interior;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    l2_r   <= side_in.last;
    nb_r   <= nb_nxt;
    dg_r   <= dg_nxt;
    far_r  <= far_nxt;
    ctr3_r <= win_r[2][2];
    l3_r   <= l2_r;
    sum_r  <= sum_nxt;
    ctr4_r <= ctr3_r;
    l4_r   <= l3_r;
  end

  assign sum_valid = v4_r;
  assign sum_out   = sum_r;
  assign ctr_out   = ctr4_r;
  assign last_out  = l4_r;
  assign busy      = {v2_r, v3_r};

endmodule

`default_nettype wire

/* src/fods_scale.sv */
// Gain multiply, round to nearest, add center and saturate.
`default_nettype none

module fods_scale (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_vld,
  input  logic signed [fods_pkg::SUM_W-1:0]         sum_in,
  input  logic signed [fods_pkg::SAMPLE_W-1:0]      ctr_in,
  input  logic                                      last_in,
  input  logic [fods_pkg::GAIN_W-1:0]               gain,
  output logic                                      res_vld,
  output fods_pkg::fods_result_t                    res
);
  import fods_pkg::*;

  logic signed [GAIN_W:0]     gain_s;
  logic signed [PROD_W-1:0]   prod_nxt, prod_r;
  logic signed [SAMPLE_W-1:0] ctr_r;
  logic                       last_r;
  logic                       vld_r;
  logic signed [PROD_W-1:0]   rnd;
  logic signed [Q_W-1:0]      q;
  logic signed [VAL_W-1:0]    v;

  assign gain_s   = {1'b0, gain};
  assign prod_nxt = PROD_W'(sum_in) * PROD_W'(gain_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    ctr_r  <= ctr_in;
    last_r <= last_in;
  end

  // Round half up, then add to center and clamp to the sample range
  always_comb begin
    rnd = prod_r + PROD_W'(32768);
    q   = rnd[PROD_W-1:16];
    v   = VAL_W'(ctr_r) + VAL_W'(q);
    res.volume_end = last_r;
    priority if (v > VAL_W'(SAMPLE_MAX)) begin
      res.value = SAMPLE_MAX;
    end else if (v < VAL_W'(SAMPLE_MIN)) begin
      res.value = SAMPLE_MIN;
    end else begin
      res.value = v[SAMPLE_W-1:0];
    end
  end

  assign res_vld = vld_r;

endmodule

`default_nettype wire

/* src/fods_out_fifo.sv */
// Small result queue that decouples the stencil pipeline from the output side.
`default_nettype none

module fods_out_fifo (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      push,
  input  fods_pkg::fods_result_t                    push_data,
  input  logic                                      pop,
  output logic                                      head_vld,
  output fods_pkg::fods_result_t                    head,
  output logic [fods_pkg::FIFO_CW-1:0]              count
);
  import fods_pkg::*;

  fods_result_t         buf_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + FIFO_CW'(1);
        2'b01:   cnt_r <= cnt_r - FIFO_CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Store the word
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_vld = (cnt_r != '0);
  assign head     = buf_r[rd_ptr_r];
  assign count    = cnt_r;

endmodule

`default_nettype wire
